/* rtl/yq2rgb_pkg.sv */
package yq2rgb_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_Y_OFFSET     = 3'd0,
    REG_LUMA_GAIN    = 3'd1,
    REG_BLUE_FROM_U  = 3'd2,
    REG_RED_FROM_V   = 3'd3,
    REG_GREEN_FROM_U = 3'd4,
    REG_GREEN_FROM_V = 3'd5
  } cfg_reg_t;

  // Reset values of the coefficient registers
  localparam logic [7:0] Y_OFFSET_RST     = 8'd16;
  localparam logic [7:0] LUMA_GAIN_RST    = 8'd149;
  localparam logic [7:0] BLUE_FROM_U_RST  = 8'd129;
  localparam logic [7:0] RED_FROM_V_RST   = 8'd102;
  localparam logic [7:0] GREEN_FROM_U_RST = 8'd50;
  localparam logic [7:0] GREEN_FROM_V_RST = 8'd104;

  // One 4:2:0 quad
  typedef struct packed {
    logic [7:0] chroma_u;
    logic [7:0] chroma_v;
    logic [7:0] luma_top_left;
    logic [7:0] luma_top_right;
    logic [7:0] luma_bottom_left;
    logic [7:0] luma_bottom_right;
  } in_word_t;

  // RGB of the four pixels of a quad
  typedef struct packed {
    logic [7:0] red_top_left;
    logic [7:0] green_top_left;
    logic [7:0] blue_top_left;
    logic [7:0] red_top_right;
    logic [7:0] green_top_right;
    logic [7:0] blue_top_right;
    logic [7:0] red_bottom_left;
    logic [7:0] green_bottom_left;
    logic [7:0] blue_bottom_left;
    logic [7:0] red_bottom_right;
    logic [7:0] green_bottom_right;
    logic [7:0] blue_bottom_right;
  } out_word_t;

  // Register write
  typedef struct packed {
    logic [2:0] reg_index;
    logic [7:0] wdata;
  } cfg_word_t;

endpackage

/* rtl/yq2rgb_in_if.sv */
interface yq2rgb_in_if;
  logic                 valid;
  logic                 ready;
  yq2rgb_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/yq2rgb_out_if.sv */
interface yq2rgb_out_if;
  logic                  valid;
  logic                  ready;
  yq2rgb_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/yq2rgb_cfg_if.sv */
interface yq2rgb_cfg_if;
  logic                  valid;
  logic                  ready;
  yq2rgb_pkg::cfg_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/yuv420_quad_to_rgb_fixed_unit.sv */
// An accepted quad word goes through the input register, then the result register.
// Throughput: one quad per cycle while the output is not stalled; the two registers
// form a two-deep pipeline that only holds while the output is stalled.
// Reset (rst_n low, synchronous): both pipeline stages empty, coefficient
// registers back to their BT.601 defaults. Config writes complete at once.
module yuv420_quad_to_rgb_fixed_unit (
  input  logic          clk,
  input  logic          rst_n,
  yq2rgb_in_if.sink     in_ch,
  yq2rgb_out_if.source  out_ch,
  yq2rgb_cfg_if.sink    cfg_ch
);
  import yq2rgb_pkg::*;

  // Coefficient registers
  logic [7:0] y_offset_r;
  logic [7:0] luma_gain_r;
  logic [7:0] blue_from_u_r;
  logic [7:0] red_from_v_r;
  logic [7:0] green_from_u_r;
  logic [7:0] green_from_v_r;

  // Pipeline registers
  logic      in_valid_r;
  in_word_t  in_word_r;
  logic      out_valid_r;
  out_word_t out_word_r;
  out_word_t out_word_nxt;

  logic in_adv;
  logic out_adv;

  // Datapath intermediates
  logic signed [7:0]  u_c;
  logic signed [7:0]  v_c;
  logic signed [16:0] r_prod;
  logic signed [16:0] b_prod;
  logic signed [16:0] gu_prod;
  logic signed [16:0] gv_prod;
  logic        [15:0] g_sum;
  logic signed [10:0] r_off;
  logic signed [10:0] b_off;
  logic signed [10:0] g_off;
  logic        [7:0]  luma [4];
  logic        [7:0]  y_red [4];
  logic        [15:0] y_prod [4];
  logic signed [10:0] y_s [4];
  logic        [7:0]  red_px [4];
  logic        [7:0]  green_px [4];
  logic        [7:0]  blue_px [4];

  // Saturate an 11-bit signed channel to 0..255
  function automatic logic [7:0] clamp8(input logic signed [10:0] x);
    logic [7:0] res;
    if (x[10]) begin
      res = 8'd0;
    end else if (|x[9:8]) begin
      res = 8'hFF;
    end else begin
      res = x[7:0];
    end
    return res;
  endfunction

  // Handshake: a stage moves when it is empty or its contents move on
  assign out_adv      = !out_valid_r || out_ch.ready;
  assign in_adv       = !in_valid_r || out_adv;
  assign in_ch.ready  = in_adv;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_word_r;
  assign cfg_ch.ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_offset_r     <= Y_OFFSET_RST;
      luma_gain_r    <= LUMA_GAIN_RST;
      blue_from_u_r  <= BLUE_FROM_U_RST;
      red_from_v_r   <= RED_FROM_V_RST;
      green_from_u_r <= GREEN_FROM_U_RST;
      green_from_v_r <= GREEN_FROM_V_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.data.reg_index)
        REG_Y_OFFSET:     y_offset_r     <= cfg_ch.data.wdata;
        REG_LUMA_GAIN:    luma_gain_r    <= cfg_ch.data.wdata;
        REG_BLUE_FROM_U:  blue_from_u_r  <= cfg_ch.data.wdata;
        REG_RED_FROM_V:   red_from_v_r   <= cfg_ch.data.wdata;
        REG_GREEN_FROM_U: green_from_u_r <= cfg_ch.data.wdata;
        REG_GREEN_FROM_V: green_from_v_r <= cfg_ch.data.wdata;
        default: ;
      endcase
    end
  end

  // Chroma offsets; offset binary to two's complement is a flip of the MSB
  always_comb begin
    u_c     = $signed({~in_word_r.chroma_u[7], in_word_r.chroma_u[6:0]});
    v_c     = $signed({~in_word_r.chroma_v[7], in_word_r.chroma_v[6:0]});
    r_prod  = $signed({{9{v_c[7]}}, v_c}) * $signed({9'd0, red_from_v_r});
    b_prod  = $signed({{9{u_c[7]}}, u_c}) * $signed({9'd0, blue_from_u_r});
    gu_prod = $signed({{9{u_c[7]}}, u_c}) * $signed({9'd0, green_from_u_r});
    gv_prod = $signed({{9{v_c[7]}}, v_c}) * $signed({9'd0, green_from_v_r});
    // green sum wraps at 16 bits
    g_sum   = gu_prod[15:0] + gv_prod[15:0];
    // floor shifts: drop the low bits of the signed value
    r_off   = r_prod[16:6];
    b_off   = b_prod[16:6];
    g_off   = $signed({{2{g_sum[15]}}, g_sum[15:7]});
  end

  // Per-pixel luma scaling and channel sums
  always_comb begin
    luma[0] = in_word_r.luma_top_left;
    luma[1] = in_word_r.luma_top_right;
    luma[2] = in_word_r.luma_bottom_left;
    luma[3] = in_word_r.luma_bottom_right;
    for (int k = 0; k < 4; k++) begin
      y_red[k]    = (luma[k] > y_offset_r) ? (luma[k] - y_offset_r) : 8'd0;
      y_prod[k]   = 16'(y_red[k]) * 16'(luma_gain_r);
      y_s[k]      = $signed({2'b00, y_prod[k][15:7]});
      red_px[k]   = clamp8(y_s[k] + r_off);
      green_px[k] = clamp8(y_s[k] - g_off);
      blue_px[k]  = clamp8(y_s[k] + b_off);
    end
  end

  // Pack the result word
  always_comb begin
    out_word_nxt.red_top_left       = red_px[0];
    out_word_nxt.green_top_left     = green_px[0];
    out_word_nxt.blue_top_left      = blue_px[0];
    out_word_nxt.red_top_right      = red_px[1];
    out_word_nxt.green_top_right    = green_px[1];
    out_word_nxt.blue_top_right     = blue_px[1];
    out_word_nxt.red_bottom_left    = red_px[2];
    out_word_nxt.green_bottom_left  = green_px[2];
    out_word_nxt.blue_bottom_left   = blue_px[2];
    out_word_nxt.red_bottom_right   = red_px[3];
    out_word_nxt.green_bottom_right = green_px[3];
    out_word_nxt.blue_bottom_right  = blue_px[3];
  end

  // Pipeline valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_adv) begin
        in_valid_r <= in_ch.valid;
      end
      if (out_adv) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (in_adv && in_ch.valid) begin
      in_word_r <= in_ch.data;
    end
    if (out_adv && in_valid_r) begin
      out_word_r <= out_word_nxt;
    end
  end

endmodule

/* verif/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import yq2rgb_pkg::*;

  localparam int REG_COUNT    = int'(REG_GREEN_FROM_V) + 1;
  localparam int CHROMA_ZERO  = 128;
  localparam int PHASES       = 8;
  localparam int RANDOM_QUADS = 150;
  localparam int DRAIN_CYCLES = 8;

  logic clk = 1'b0;
  logic rst_n;

  yq2rgb_in_if  in_ch();
  yq2rgb_out_if out_ch();
  yq2rgb_cfg_if cfg_ch();

  yuv420_quad_to_rgb_fixed_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #6 clk = ~clk;

  // Quads waiting to be sent, and RGB words still owed by the block
  in_word_t  quad_pending[$];
  out_word_t rgb_expected[$];
  int        fail_count     = 0;
  int        send_gap_pct   = 0;
  int        recv_stall_pct = 0;
  logic      hold_input     = 1'b0;

  // Our own copy of the coefficient registers
  logic [7:0] y_offset_c     = Y_OFFSET_RST;
  logic [7:0] luma_gain_c    = LUMA_GAIN_RST;
  logic [7:0] blue_from_u_c  = BLUE_FROM_U_RST;
  logic [7:0] red_from_v_c   = RED_FROM_V_RST;
  logic [7:0] green_from_u_c = GREEN_FROM_U_RST;
  logic [7:0] green_from_v_c = GREEN_FROM_V_RST;

  string rgb_field_name[12] = '{
    "red_top_left", "green_top_left", "blue_top_left",
    "red_top_right", "green_top_right", "blue_top_right",
    "red_bottom_left", "green_bottom_left", "blue_bottom_left",
    "red_bottom_right", "green_bottom_right", "blue_bottom_right"
  };

  function automatic logic [7:0] sat8(int x);
    if (x < 0) return 8'd0;
    if (x > 255) return 8'd255;
    return x[7:0];
  endfunction

  // Expected RGB for one quad under the current coefficients
  function automatic out_word_t quad_to_rgb(in_word_t q);
    int               u, v, red_add, blue_add, green_sub, lum;
    logic signed [15:0] green_sum;
    logic [7:0]       luma [4];
    logic [11:0][7:0] rgb;
    luma = '{q.luma_top_left, q.luma_top_right, q.luma_bottom_left, q.luma_bottom_right};
    u = int'(q.chroma_u) - CHROMA_ZERO;
    v = int'(q.chroma_v) - CHROMA_ZERO;
    red_add  = (v * int'(red_from_v_c)) >>> 6;
    blue_add = (u * int'(blue_from_u_c)) >>> 6;
    // green sum wraps at 16 bits before the floor shift
    green_sum = 16'(u * int'(green_from_u_c) + v * int'(green_from_v_c));
    green_sub = int'(green_sum) >>> 7;
    for (int k = 0; k < 4; k++) begin
      lum = (luma[k] > y_offset_c) ? int'(luma[k]) - int'(y_offset_c) : 0;
      lum = ((lum * int'(luma_gain_c)) & 'hFFFF) >> 7;
      rgb[11 - 3*k] = sat8(lum + red_add);
      rgb[10 - 3*k] = sat8(lum - green_sub);
      rgb[9 - 3*k]  = sat8(lum + blue_add);
    end
    return out_word_t'(rgb);
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [7:0] val);
    case (cfg_reg_t'(idx))
      REG_Y_OFFSET:     y_offset_c     = val;
      REG_LUMA_GAIN:    luma_gain_c    = val;
      REG_BLUE_FROM_U:  blue_from_u_c  = val;
      REG_RED_FROM_V:   red_from_v_c   = val;
      REG_GREEN_FROM_U: green_from_u_c = val;
      REG_GREEN_FROM_V: green_from_v_c = val;
      default: ;
    endcase
  endfunction

  // Biased towards the ends and the chroma centre
  function automatic logic [7:0] pick_byte();
    int sel;
    sel = $urandom_range(9);
    case (sel)
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'(CHROMA_ZERO);
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic in_word_t make_quad(logic [7:0] u, logic [7:0] v, logic [7:0] tl,
                                         logic [7:0] tr, logic [7:0] bl, logic [7:0] br);
    in_word_t q;
    q = '{u, v, tl, tr, bl, br};
    return q;
  endfunction

  // Input driver: next word only once the current one has gone
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (quad_pending.size() != 0 && !hold_input && $urandom_range(99) >= send_gap_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.data  <= quad_pending.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  task automatic check_rgb(out_word_t got);
    out_word_t        want;
    logic [11:0][7:0] g, w;
    if (rgb_expected.size() == 0) begin
      $display("%0t: RGB word with none expected: %h", $time, got);
      fail_count++;
      return;
    end
    want = rgb_expected.pop_front();
    g = got;
    w = want;
    for (int k = 0; k < 12; k++) begin
      if (g[11 - k] !== w[11 - k]) begin
        $display("%0t: %s expected %0d got %0d", $time, rgb_field_name[k], w[11 - k], g[11 - k]);
        fail_count++;
      end
    end
  endtask

  // Output side: random back-pressure, check words, predict on input accept
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_ch.valid && out_ch.ready) check_rgb(out_ch.data);
      if (in_ch.valid && in_ch.ready) rgb_expected.push_back(quad_to_rgb(in_ch.data));
    end
  end

  task automatic wait_idle();
    do @(negedge clk);
    while (quad_pending.size() != 0 || in_ch.valid || rgb_expected.size() != 0);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= '{idx, val};
    do @(posedge clk);
    while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    apply_reg(idx, val);
  endtask

  // Extremes, neutral chroma and the black-level edge
  task automatic queue_directed_quads();
    quad_pending.push_back(make_quad(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    quad_pending.push_back(make_quad(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
    quad_pending.push_back(make_quad(8'd128, 8'd128, 8'd0, 8'd15, 8'd16, 8'd17));
    quad_pending.push_back(make_quad(8'd128, 8'd128, 8'd235, 8'd240, 8'd254, 8'd255));
    quad_pending.push_back(make_quad(8'd0, 8'd255, 8'd16, 8'd128, 8'd200, 8'd255));
    quad_pending.push_back(make_quad(8'd255, 8'd0, 8'd16, 8'd128, 8'd200, 8'd255));
    quad_pending.push_back(make_quad(8'd0, 8'd0, 8'd255, 8'd128, 8'd64, 8'd0));
    quad_pending.push_back(make_quad(8'd255, 8'd255, 8'd0, 8'd64, 8'd128, 8'd255));
    quad_pending.push_back(make_quad(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55));
    quad_pending.push_back(make_quad(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA));
    quad_pending.push_back(make_quad(8'd127, 8'd129, 8'd1, 8'd254, 8'd127, 8'd128));
    quad_pending.push_back(make_quad(8'd1, 8'd254, 8'd100, 8'd50, 8'd25, 8'd12));
  endtask

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      // coefficient setting for this phase
      case (p)
        0: ;
        1: for (int r = 0; r < REG_COUNT; r++) write_reg(3'(r), 8'd0);
        2: for (int r = 0; r < REG_COUNT; r++) write_reg(3'(r), 8'd255);
        PHASES - 1: begin
          write_reg(REG_Y_OFFSET, Y_OFFSET_RST);
          write_reg(REG_LUMA_GAIN, LUMA_GAIN_RST);
          write_reg(REG_BLUE_FROM_U, BLUE_FROM_U_RST);
          write_reg(REG_RED_FROM_V, RED_FROM_V_RST);
          write_reg(REG_GREEN_FROM_U, GREEN_FROM_U_RST);
          write_reg(REG_GREEN_FROM_V, GREEN_FROM_V_RST);
        end
        default: for (int r = 0; r < REG_COUNT; r++) write_reg(3'(r), pick_byte());
      endcase
      // writes past the register list must leave everything alone
      if (p == 3) begin
        write_reg(3'(REG_COUNT), 8'hFF);
        write_reg(3'(REG_COUNT + 1), 8'h00);
      end

      case (p % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 55; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 55; end
        default: begin send_gap_pct = 37; recv_stall_pct = 37; end
      endcase

      @(negedge clk);
      if (p == 0 || p == 2) queue_directed_quads();
      for (int i = 0; i < RANDOM_QUADS; i++)
        quad_pending.push_back(make_quad(pick_byte(), pick_byte(), pick_byte(),
                                         pick_byte(), pick_byte(), pick_byte()));

      // hold the sender until the pipeline has drained completely
      if (p == 5) begin
        while (quad_pending.size() > RANDOM_QUADS / 2) @(negedge clk);
        hold_input = 1'b1;
        do @(negedge clk);
        while (in_ch.valid || rgb_expected.size() != 0);
        hold_input = 1'b0;
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS yuv420_quad_to_rgb_fixed_unit");
    end else begin
      $display("FAIL yuv420_quad_to_rgb_fixed_unit");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("FAIL yuv420_quad_to_rgb_fixed_unit");
    $finish;
  end

endmodule

/* files.f */
rtl/yq2rgb_pkg.sv
rtl/yq2rgb_in_if.sv
rtl/yq2rgb_out_if.sv
rtl/yq2rgb_cfg_if.sv
rtl/yuv420_quad_to_rgb_fixed_unit.sv
verif/tb_top.sv
